// ===== rtl/bap_pkg.sv =====
// Package for the block-average pixelate block.
// Holds the default bounds, register indexes and the pixel and cell payload types.
// No dependencies.
package bap_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_CELL   = 64;
  localparam int JOB_DEPTH      = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_index_t;

  localparam logic [6:0]  RST_CELL_SIZE    = 7'd8;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [9:0] cell_col;
    logic [9:0] cell_row;
    logic [6:0] cell_w;
    logic [6:0] cell_h;
    logic [7:0] red_mean;
    logic [7:0] green_mean;
    logic [7:0] blue_mean;
    logic       frame_last;
  } cell_t;

endpackage

// ===== rtl/bap_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Reads return the old contents when the same entry is written in that cycle.
// No dependencies.
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bap_fifo.sv =====
// Short job queue between the accumulating front end and the dividing back end.
// Holds finished cell sums; depends on nothing else.
module bap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign rd_data = slots[rd_ptr];
  assign empty   = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= PW'((wr_ptr + 1'b1) % DEPTH);
      end
      if (rd_en) begin
        rd_ptr <= PW'((rd_ptr + 1'b1) % DEPTH);
      end
      count <= count + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != ($clog2(DEPTH+1))'(DEPTH)) || rd_en)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> count != '0)
    else $error("job queue read while empty");

endmodule

// ===== rtl/bap_front.sv =====
// Front end: configuration registers, raster position tracking and per-column
// channel accumulation in a RAM; emits one job per finished cell. Uses bap_pkg, bap_ram.
module bap_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_CELL   = 64,
  parameter int DEPTH      = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              push,
  output logic                              full,
  input  bap_pkg::pixel_t                   pixel,
  input  logic [$clog2(DEPTH+1)-1:0]        q_count,
  output logic                              job_push,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+4*($clog2(MAX_CELL)+1)
                +3*(8+2*$clog2(MAX_CELL))+1-1:0] job_data
);
  import bap_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int CW   = $clog2(MAX_CELL);
  localparam int DW   = CW + 1;
  localparam int SW   = 8 + 2 * CW;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int KW   = $clog2(MAX_CELL + 1);
  localparam int QCW  = $clog2(DEPTH + 1);

  logic [6:0]  reg_cell;
  logic [10:0] reg_width;
  logic [10:0] reg_height;

  logic [KW-1:0] cs;
  logic [WW-1:0] wc;
  logic [HW-1:0] hc;

  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;
  logic [CW-1:0] col_in_cell;
  logic [CW-1:0] row_in_cell;
  logic [XW-1:0] cell_x;
  logic [YW-1:0] cell_y;

  logic accept, row_end, frame_end, cell_right, cell_bottom;

  logic            s1_valid, s1_first, s1_fwd, s1_emit, s1_last;
  pixel_t          s1_px;
  logic [XW-1:0]   s1_col;
  logic [YW-1:0]   s1_row;
  logic [DW-1:0]   s1_w, s1_h;
  logic [3*SW-1:0] rdata, base, new_sum, last_sum;
  logic [2*DW-1:0] s1_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_cell   <= RST_CELL_SIZE;
      reg_width  <= RST_IMAGE_WIDTH;
      reg_height <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CELL_SIZE:    reg_cell   <= cfg_data[6:0];
        REG_IMAGE_WIDTH:  reg_width  <= cfg_data;
        REG_IMAGE_HEIGHT: reg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero register acts as one, and values above the bounds saturate.
  always_comb begin
    if (reg_cell == '0) cs = KW'(1);
    else if (32'(reg_cell) > MAX_CELL) cs = KW'(MAX_CELL);
    else cs = KW'(reg_cell);
    if (reg_width == '0) wc = WW'(1);
    else if (32'(reg_width) > MAX_WIDTH) wc = WW'(MAX_WIDTH);
    else wc = WW'(reg_width);
    if (reg_height == '0) hc = HW'(1);
    else if (32'(reg_height) > MAX_HEIGHT) hc = HW'(MAX_HEIGHT);
    else hc = HW'(reg_height);
  end

  assign row_end     = WW'(pixel_x) >= wc - 1'b1;
  assign frame_end   = row_end && (HW'(pixel_y) >= hc - 1'b1);
  assign cell_right  = row_end || (KW'(col_in_cell) >= cs - 1'b1);
  assign cell_bottom = (HW'(pixel_y) >= hc - 1'b1) || (KW'(row_in_cell) >= cs - 1'b1);

  // Room must remain for the job the accumulator may push now and one more.
  assign job_push = s1_valid && s1_emit;
  assign full     = (32'(q_count) + (job_push ? 1 : 0)) >= DEPTH;
  assign accept   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_x     <= '0;
      pixel_y     <= '0;
      col_in_cell <= '0;
      row_in_cell <= '0;
      cell_x      <= '0;
      cell_y      <= '0;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (row_end) begin
          pixel_x     <= '0;
          col_in_cell <= '0;
          cell_x      <= '0;
          if (frame_end) begin
            pixel_y     <= '0;
            row_in_cell <= '0;
            cell_y      <= '0;
          end else begin
            pixel_y <= pixel_y + 1'b1;
            if (cell_bottom) begin
              row_in_cell <= '0;
              cell_y      <= cell_y + 1'b1;
            end else begin
              row_in_cell <= row_in_cell + 1'b1;
            end
          end
        end else begin
          pixel_x <= pixel_x + 1'b1;
          if (cell_right) begin
            col_in_cell <= '0;
            cell_x      <= cell_x + 1'b1;
          end else begin
            col_in_cell <= col_in_cell + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= pixel;
      s1_first <= (col_in_cell == '0) && (row_in_cell == '0);
      // The entry being written this cycle is not yet visible to the read.
      s1_fwd   <= s1_valid && (s1_col == cell_x);
      s1_emit  <= cell_right && cell_bottom;
      s1_last  <= frame_end;
      s1_col   <= cell_x;
      s1_row   <= cell_y;
      s1_w     <= DW'(col_in_cell) + 1'b1;
      s1_h     <= DW'(row_in_cell) + 1'b1;
    end
    if (s1_valid) begin
      last_sum <= new_sum;
    end
  end

  bap_ram #(.WIDTH(3 * SW), .DEPTH(MAX_WIDTH)) u_sums (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (new_sum),
    .raddr (cell_x),
    .rdata (rdata)
  );

  assign base = s1_fwd ? last_sum : rdata;

  always_comb begin
    if (s1_first) begin
      new_sum = {SW'(s1_px.red_in), SW'(s1_px.green_in), SW'(s1_px.blue_in)};
    end else begin
      new_sum = {base[3*SW-1:2*SW] + SW'(s1_px.red_in),
                 base[2*SW-1:SW]   + SW'(s1_px.green_in),
                 base[SW-1:0]      + SW'(s1_px.blue_in)};
    end
  end

  assign s1_count = s1_w * s1_h;
  assign job_data = {s1_col, s1_row, s1_w, s1_h, s1_count, new_sum, s1_last};

  a_fwd_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd) |-> $past(s1_valid))
    else $error("forwarded sum without a preceding accumulation");

endmodule

// ===== rtl/bap_back.sv =====
// Back end: takes cell jobs from the queue and divides the three channel sums
// by the cell area, one quotient bit per cycle, into the result register. Uses bap_pkg.
module bap_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_CELL   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+4*($clog2(MAX_CELL)+1)
                +3*(8+2*$clog2(MAX_CELL))+1-1:0] job,
  output logic                  empty,
  input  logic                  pop,
  output bap_pkg::cell_t        result
);
  import bap_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_CELL);
  localparam int DW  = CW + 1;
  localparam int KNW = 2 * DW;
  localparam int SW  = 8 + 2 * CW;
  localparam int NW  = SW + 1;
  localparam int IW  = $clog2(NW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t         state;
  logic [IW-1:0]  iter;
  logic [XW-1:0]  j_col;
  logic [YW-1:0]  j_row;
  logic [DW-1:0]  j_w, j_h;
  logic [KNW-1:0] j_cnt;
  logic [SW-1:0]  j_sum [3];
  logic           j_last;
  logic [KNW-1:0] divisor;
  logic [NW-1:0]  quo [3];
  logic [KNW:0]   rem [3];
  logic [KNW+1:0] trial [3];
  logic [7:0]     mean [3];
  logic           res_valid, load_res;
  logic [XW-1:0]  result_meta_col;
  logic [YW-1:0]  result_meta_row;
  logic [DW-1:0]  result_meta_w, result_meta_h;
  logic           result_meta_last;

  assign {j_col, j_row, j_w, j_h, j_cnt, j_sum[0], j_sum[1], j_sum[2], j_last} = job;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign load_res = (state == ST_DONE) && (!res_valid || pop);
  assign empty    = !res_valid;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c], quo[c][NW-1]};
      mean[c]  = (|quo[c][NW-1:8]) ? 8'hFF : quo[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      iter      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_DIV;
            iter  <= '0;
          end
        end
        ST_DIV: begin
          iter <= iter + 1'b1;
          if (iter == IW'(NW - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_res) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Restoring division of (sum + count/2) by count for the three channels.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      divisor <= j_cnt;
      result_meta_col  <= j_col;
      result_meta_row  <= j_row;
      result_meta_w    <= j_w;
      result_meta_h    <= j_h;
      result_meta_last <= j_last;
      for (int c = 0; c < 3; c++) begin
        quo[c] <= NW'(j_sum[c]) + NW'(j_cnt >> 1);
        rem[c] <= '0;
      end
    end else if (state == ST_DIV) begin
      for (int c = 0; c < 3; c++) begin
        if (trial[c] >= (KNW+2)'(divisor)) begin
          rem[c] <= (KNW+1)'(trial[c] - (KNW+2)'(divisor));
          quo[c] <= {quo[c][NW-2:0], 1'b1};
        end else begin
          rem[c] <= (KNW+1)'(trial[c]);
          quo[c] <= {quo[c][NW-2:0], 1'b0};
        end
      end
    end
    if (load_res) begin
      result.cell_col   <= 10'(result_meta_col);
      result.cell_row   <= 10'(result_meta_row);
      result.cell_w     <= 7'(result_meta_w);
      result.cell_h     <= 7'(result_meta_h);
      result.red_mean   <= mean[0];
      result.green_mean <= mean[1];
      result.blue_mean  <= mean[2];
      result.frame_last <= result_meta_last;
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (32'(iter) < NW))
    else $error("divider ran past its last step");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_DIV) && (iter == '0))
    else $error("job taken without starting a division");

endmodule

// ===== rtl/block_average_pixelate.sv =====
// Block-average pixelate: RGB pixels in raster order go in through a queue-style
// port (push/full); one result per finished mosaic cell comes out (empty/pop).
// Configuration (cell_size, image_width, image_height) is written through
// cfg_we/cfg_index/cfg_data while the block is idle; values take effect at once.
// A pixel is taken at every edge with push high and full low, so the input
// runs at one pixel per clock. The accumulator reads and writes one RAM entry
// per cell column, with the newest sum forwarded to the next pixel.
// A cell's bottom-right pixel finishes its sums in the cycle after it is taken
// and drops a job into a four-entry queue. The back end divides each job's sums
// by the cell area one quotient bit per cycle and takes the next job only once
// the result of the last one has been loaded into the result register.
// When pop stays low the result register holds, the back end and then the queue
// fill, and full rises, stalling the pixel input. Reset returns the registers to
// 8/640/480 and the position to the top left of a frame; the accumulator RAM
// needs no clearing, since the first pixel of each cell overwrites its entry.
// Depends on bap_pkg, bap_front, bap_fifo, bap_back, bap_ram.
module block_average_pixelate #(
  parameter int MAX_WIDTH  = bap_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bap_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CELL   = bap_pkg::DEF_MAX_CELL
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  bap_pkg::pixel_t                pixel,
  output logic                           empty,
  input  logic                           pop,
  output bap_pkg::cell_t                 result
);
  import bap_pkg::*;

  localparam int CW = $clog2(MAX_CELL);
  localparam int JW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 4 * (CW + 1)
                      + 3 * (8 + 2 * CW) + 1;
  localparam int QCW = $clog2(JOB_DEPTH + 1);

  logic          job_push, q_pop, q_empty;
  logic [JW-1:0] job_in, job_out;
  logic [QCW-1:0] q_count;

  bap_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_CELL  (MAX_CELL),
    .DEPTH     (JOB_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .pixel    (pixel),
    .q_count  (q_count),
    .job_push (job_push),
    .job_data (job_in)
  );

  bap_fifo #(.WIDTH(JW), .DEPTH(JOB_DEPTH)) u_jobs (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_data(job_in),
    .rd_en  (q_pop),
    .rd_data(job_out),
    .empty  (q_empty),
    .count  (q_count)
  );

  bap_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_CELL  (MAX_CELL)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .job    (job_out),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== tb/tb_block_average_pixelate.sv =====
// Testbench for block_average_pixelate: pixels are pushed in raster order under
// several cell and frame settings, and each finished cell is checked against a predictor.
// Depends on bap_pkg and the block_average_pixelate RTL.
module tb_block_average_pixelate;
  timeunit 1ns;
  timeprecision 1ps;
  import bap_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 40;
  localparam int RANDOM_PIXELS = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  pixel_t pixel = '0;
  logic empty;
  logic pop = 1'b0;
  cell_t result;

  block_average_pixelate uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .pixel(pixel), .empty(empty), .pop(pop), .result(result)
  );

  always #6 clk = ~clk;

  // Predictor state: registers as written, position in the frame, column sums.
  logic [6:0] cell_size_q;
  logic [10:0] width_q, height_q;
  int unsigned col_sums[1024][3];
  int unsigned pos_x, pos_y, x_in_cell, y_in_cell, cell_x_q, cell_y_q;

  cell_t expected_cells[$];
  int mismatches = 0;
  int accepted = 0;
  bit calm = 1'b0;

  function automatic int unsigned clip_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] mean8(int unsigned sum, int unsigned cnt);
    int unsigned m;
    m = (sum + cnt / 2) / cnt;
    return (m > 255) ? 8'd255 : m[7:0];
  endfunction

  // Advances the predicted position by one pixel; returns 1 when a cell finishes.
  function automatic bit predict_cell(pixel_t p, output cell_t c);
    int unsigned cs, w, h, slot, chan[3], cnt;
    bit row_end, frame_end, right, bottom;
    cs = clip_reg(cell_size_q, 64);
    w = clip_reg(width_q, 1024);
    h = clip_reg(height_q, 1024);
    slot = (cell_x_q < 1024) ? cell_x_q : 1023;
    row_end = pos_x >= w - 1;
    frame_end = row_end && pos_y >= h - 1;
    right = row_end || x_in_cell >= cs - 1;
    bottom = pos_y >= h - 1 || y_in_cell >= cs - 1;
    chan[0] = p.red_in;
    chan[1] = p.green_in;
    chan[2] = p.blue_in;
    for (int i = 0; i < 3; i++) begin
      if (x_in_cell == 0 && y_in_cell == 0) col_sums[slot][i] = chan[i];
      else col_sums[slot][i] += chan[i];
    end
    c = '0;
    predict_cell = right && bottom;
    if (predict_cell) begin
      cnt = (x_in_cell + 1) * (y_in_cell + 1);
      c.cell_col = cell_x_q[9:0];
      c.cell_row = cell_y_q[9:0];
      c.cell_w = 7'(x_in_cell + 1);
      c.cell_h = 7'(y_in_cell + 1);
      c.red_mean = mean8(col_sums[slot][0], cnt);
      c.green_mean = mean8(col_sums[slot][1], cnt);
      c.blue_mean = mean8(col_sums[slot][2], cnt);
      c.frame_last = frame_end;
    end
    if (row_end) begin
      pos_x = 0;
      x_in_cell = 0;
      cell_x_q = 0;
      if (frame_end) begin
        pos_y = 0;
        y_in_cell = 0;
        cell_y_q = 0;
      end else begin
        pos_y++;
        if (bottom) begin
          y_in_cell = 0;
          cell_y_q++;
        end else begin
          y_in_cell++;
        end
      end
    end else begin
      pos_x++;
      if (right) begin
        x_in_cell = 0;
        cell_x_q++;
      end else begin
        x_in_cell++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, cell_t want, cell_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %h actual %h", what, want, got);
  endtask

  // Sends one pixel request and waits until the block takes it.
  task automatic send_pixel(pixel_t p, bit typed, cell_t want);
    cell_t c;
    bit hit;
    push <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (full);
    hit = predict_cell(p, c);
    if (typed) begin
      if (!hit || c !== want) report_mismatch("predictor vs table", want, c);
      expected_cells.push_back(want);
    end else if (hit) begin
      expected_cells.push_back(c);
    end
    if (!calm && $urandom_range(99) < 30) begin
      push <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [10:0] val);
    push <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CELL_SIZE: cell_size_q = val[6:0];
      REG_IMAGE_WIDTH: width_q = val;
      default: height_q = val;
    endcase
  endtask

  task automatic set_geometry(logic [10:0] cs, logic [10:0] w, logic [10:0] h);
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'($urandom);
    if ($urandom_range(9) == 0) p = $urandom_range(1) ? '1 : '0;
    return p;
  endfunction

  // Directed rows: register writes and pixels, with typed results where obvious.
  typedef struct {
    bit is_cfg;
    reg_index_t idx;
    logic [10:0] val;
    pixel_t px;
    bit typed;
    cell_t want;
  } step_t;

  step_t plan[$];

  function automatic void add_cfg(reg_index_t idx, logic [10:0] val);
    plan.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endfunction

  function automatic void add_px(pixel_t p);
    plan.push_back('{1'b0, REG_CELL_SIZE, '0, p, 1'b0, '0});
  endfunction

  // A one-pixel frame: the cell is the pixel itself and always the last one.
  function automatic void add_single(pixel_t p);
    plan.push_back('{1'b0, REG_CELL_SIZE, '0, p, 1'b1,
                     '{10'd0, 10'd0, 7'd1, 7'd1, p.red_in, p.green_in, p.blue_in, 1'b1}});
  endfunction

  initial begin
    cell_t dummy;
    cell_size_q = RST_CELL_SIZE;
    width_q = RST_IMAGE_WIDTH;
    height_q = RST_IMAGE_HEIGHT;
    pos_x = 0; pos_y = 0; x_in_cell = 0; y_in_cell = 0; cell_x_q = 0; cell_y_q = 0;
    foreach (col_sums[i, j]) col_sums[i][j] = 0;
    dummy = '0;

    // Zero registers act as one, giving one-pixel frames.
    add_cfg(REG_CELL_SIZE, 11'd1);
    add_cfg(REG_IMAGE_WIDTH, 11'd0);
    add_cfg(REG_IMAGE_HEIGHT, 11'd0);
    add_single('{8'h00, 8'h00, 8'h00});
    add_single('{8'hFF, 8'hFF, 8'hFF});
    add_single('{8'hA5, 8'h5A, 8'h0F});
    // Clipped right column on a 3x2 frame with 2x2 cells.
    add_cfg(REG_CELL_SIZE, 11'd2);
    add_cfg(REG_IMAGE_WIDTH, 11'd3);
    add_cfg(REG_IMAGE_HEIGHT, 11'd2);
    for (int i = 0; i < 6; i++) add_px('{8'(i * 40), 8'(255 - i), 8'(i[0] ? 255 : 0)});
    // A full 4x2 frame, then the cell size grows in the middle of the next one,
    // so the last cell mixes both geometries.
    add_cfg(REG_IMAGE_WIDTH, 11'd4);
    for (int i = 0; i < 13; i++) add_px('{8'(i * 17), 8'hFF, 8'(i * 3)});
    add_cfg(REG_CELL_SIZE, 11'd4);
    add_px('{8'hFF, 8'hFF, 8'hFF});
    add_px('{8'h01, 8'h80, 8'h7F});
    add_px('{8'h40, 8'h00, 8'hC3});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_pixel(plan[i].px, plan[i].typed, plan[i].want);
    end

    // Oversized registers saturate: four 64-pixel cells along a wide row. The
    // one-column geometry that follows ends that row at once and then fills
    // one tall cell whose column entry still holds the first cell's sums.
    set_geometry(11'd127, 11'd2047, 11'd1);
    repeat (256) send_pixel(random_pixel(), 1'b0, dummy);
    set_geometry(11'd64, 11'd1, 11'd2047);
    repeat (64) send_pixel(random_pixel(), 1'b0, dummy);

    // Random geometries, whole frames each, mostly small cells.
    begin
      int sent;
      int unsigned cs, w, h, n;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
        cs = ($urandom_range(9) < 7) ? $urandom_range(8, 1) : $urandom_range(64, 0);
        w = $urandom_range(16, 1);
        h = $urandom_range(8, 1);
        if ($urandom_range(9) == 0) w = 0;
        n = w * h * $urandom_range(2, 1);
        if (w == 0) n = h;
        set_geometry(11'(cs), 11'(w), 11'(h));
        repeat (n) begin
          calm = (sent >= 200 && sent < 400);
          send_pixel(random_pixel(), 1'b0, dummy);
          sent++;
        end
      end
      calm = 1'b0;
    end

    push <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Result side: checks each accepted cell and stalls at random, with one long hold-off.
  initial begin
    cell_t want;
    int hold;
    bit held_once;
    hold = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        accepted++;
        if (expected_cells.size() == 0) begin
          report_mismatch("unexpected cell", '0, result);
        end else begin
          want = expected_cells.pop_front();
          if (result.cell_col !== want.cell_col || result.cell_row !== want.cell_row ||
              result.cell_w !== want.cell_w || result.cell_h !== want.cell_h ||
              result.red_mean !== want.red_mean || result.green_mean !== want.green_mean ||
              result.blue_mean !== want.blue_mean || result.frame_last !== want.frame_last)
            report_mismatch("cell", want, result);
        end
      end
      if (!held_once && accepted >= 40) begin
        held_once = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // Watchdog on cycles without any accepted request on either side.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_we || rst) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
